### src/lfpd_pkg.sv
// shared widths, register map, reset values and helper functions for the line follower drive
package lfpd_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int IN_TDATA_W  = 56;
  localparam int DRIVE_W     = 16;
  localparam int ERR_W       = 3;
  localparam int OUT_TDATA_W = 40;
  localparam int SUM_W       = 16;
  localparam int D_W         = 4;
  localparam int C_W         = 30;
  localparam int ACC_W       = 32;

  localparam int THR_W  = 10;
  localparam int GAIN_W = 12;
  localparam int BASE_W = 13;

  localparam int ADDR_W     = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_GAIN_P    = 3'd1;
  localparam logic [2:0] REG_GAIN_I    = 3'd2;
  localparam logic [2:0] REG_GAIN_D    = 3'd3;
  localparam logic [2:0] REG_BASE      = 3'd4;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 10'd400;
  localparam logic [GAIN_W-1:0] GAIN_P_RST    = 12'd438;
  localparam logic [GAIN_W-1:0] GAIN_I_RST    = 12'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RST    = 12'd384;
  localparam logic [BASE_W-1:0] BASE_RST      = 13'd1664;

  localparam logic signed [ACC_W-1:0] DRIVE_MAX = 32'sd32767;

  localparam logic signed [ERR_W-1:0] ERR_ZERO      = 3'sd0;
  localparam logic signed [ERR_W-1:0] ERR_LEFT_ONE  = 3'sd1;
  localparam logic signed [ERR_W-1:0] ERR_LEFT_TWO  = 3'sd2;
  localparam logic signed [ERR_W-1:0] ERR_RIGHT_ONE = -3'sd1;
  localparam logic signed [ERR_W-1:0] ERR_RIGHT_TWO = -3'sd2;

  // see bits: [4] far left, [3] left, [2] mid, [1] right, [0] far right
  function automatic logic signed [ERR_W-1:0] line_error(
    input logic [4:0]              see,
    input logic signed [ERR_W-1:0] prev
  );
    logic signed [ERR_W-1:0] err;
    err = prev;
    if (!see[3] && !see[1] && see[2]) begin
      err = ERR_ZERO;
    end else begin
      case (see)
        5'b00010: err = ERR_RIGHT_ONE;
        5'b01000: err = ERR_LEFT_ONE;
        5'b00001: err = ERR_RIGHT_TWO;
        5'b10000: err = ERR_LEFT_TWO;
        5'b11100: err = ERR_ZERO;
        default:  err = prev;
      endcase
    end
    return err;
  endfunction

  function automatic logic signed [DRIVE_W-1:0] clamp_drive(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > DRIVE_MAX) begin
      r = DRIVE_MAX;
    end else if (v < -DRIVE_MAX) begin
      r = -DRIVE_MAX;
    end
    return r[DRIVE_W-1:0];
  endfunction

endpackage

### src/line_follow_pid_drive.sv
// five-sensor pid line follower: sensor pipeline, pid math and wheel steering
//
// channel  dir  handshake        payload
// s_*      in   tvalid/tready    tdata: far_left, left, mid, right, far_right samples
// m_*      out  tvalid/tready    tdata: left_drive, right_drive, position_error
// apb      in   psel/penable     five config registers at 4*i, pready tied high
//
// one beat per cycle sustained while m_tready is high; each result passes through these
// registers in order before it is on m_tdata
// (input register, error/integral stage, pid sum stage, output register)
// each stage moves when the next one is empty or moving, so bubbles collapse and
// an input beat is taken while a finished result waits in the output register
// rst clears valids, pid state and config registers to their reset values
module line_follow_pid_drive (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [9:0] far_left_sample, [19:10] left_sample, [29:20] mid_sample,
  // [39:30] right_sample, [49:40] far_right_sample, [55:50] zero
  input  logic [lfpd_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] left_drive, [31:16] right_drive, [34:32] position_error, [39:35] zero
  output logic [lfpd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lfpd_pkg::ADDR_W-1:0]       paddr,
  input  logic [lfpd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lfpd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lfpd_pkg::*;

  // config registers
  logic [THR_W-1:0]  line_threshold;
  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_i;
  logic [GAIN_W-1:0] gain_d;
  logic [BASE_W-1:0] base_speed;

  logic       cfg_we;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      line_threshold <= THRESHOLD_RST;
      gain_p         <= GAIN_P_RST;
      gain_i         <= GAIN_I_RST;
      gain_d         <= GAIN_D_RST;
      base_speed     <= BASE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_THRESHOLD: line_threshold <= pwdata[THR_W-1:0];
        REG_GAIN_P:    gain_p         <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:    gain_i         <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:    gain_d         <= pwdata[GAIN_W-1:0];
        REG_BASE:      base_speed     <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_THRESHOLD: prdata = APB_DATA_W'(line_threshold);
      REG_GAIN_P:    prdata = APB_DATA_W'(gain_p);
      REG_GAIN_I:    prdata = APB_DATA_W'(gain_i);
      REG_GAIN_D:    prdata = APB_DATA_W'(gain_d);
      REG_BASE:      prdata = APB_DATA_W'(base_speed);
      default:       prdata = '0;
    endcase
  end

  // pipeline flow control
  logic in_v, s1_v, s2_v, out_v;
  logic in_rdy, s1_rdy, s2_rdy, out_rdy;

  assign out_rdy  = !out_v || m_tready;
  assign s2_rdy   = !s2_v || out_rdy;
  assign s1_rdy   = !s1_v || s2_rdy;
  assign in_rdy   = !in_v || s1_rdy;
  assign s_tready = in_rdy;
  assign m_tvalid = out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (in_rdy)  in_v  <= s_tvalid;
      if (s1_rdy)  s1_v  <= in_v;
      if (s2_rdy)  s2_v  <= s1_v;
      if (out_rdy) out_v <= s2_v;
    end
  end

  // input register
  logic [SAMPLE_W*5-1:0] in_samples;

  always_ff @(posedge clk) begin
    if (s_tvalid && in_rdy) in_samples <= s_tdata[SAMPLE_W*5-1:0];
  end

  // stage 1: line position, integral and derivative, pid state update
  logic [4:0]              see;
  logic signed [ERR_W-1:0] err_next;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [D_W-1:0]   d_next;

  logic signed [ERR_W-1:0] prev_error;
  logic signed [SUM_W-1:0] error_sum;
  logic signed [ERR_W-1:0] s1_err;
  logic signed [SUM_W-1:0] s1_sum;
  logic signed [D_W-1:0]   s1_d;

  always_comb begin
    see[4] = in_samples[SAMPLE_W-1:0]            < line_threshold;
    see[3] = in_samples[2*SAMPLE_W-1:SAMPLE_W]   < line_threshold;
    see[2] = in_samples[3*SAMPLE_W-1:2*SAMPLE_W] < line_threshold;
    see[1] = in_samples[4*SAMPLE_W-1:3*SAMPLE_W] < line_threshold;
    see[0] = in_samples[5*SAMPLE_W-1:4*SAMPLE_W] < line_threshold;
    err_next = line_error(see, prev_error);
    sum_wide = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err_next);
    // top two bits disagree on overflow
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
    d_next = D_W'(err_next) - D_W'(prev_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      error_sum  <= '0;
    end else if (in_v && s1_rdy) begin
      prev_error <= err_next;
      error_sum  <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v && s1_rdy) begin
      s1_err <= err_next;
      s1_sum <= sum_next;
      s1_d   <= d_next;
    end
  end

  // stage 2: correction c = kp*e + ki*sum + kd*d
  logic signed [C_W-1:0]   kp_ext, ki_ext, kd_ext;
  logic signed [C_W-1:0]   c_next;
  logic signed [C_W-1:0]   s2_c;
  logic signed [ERR_W-1:0] s2_err;

  assign kp_ext = C_W'($signed({1'b0, gain_p}));
  assign ki_ext = C_W'($signed({1'b0, gain_i}));
  assign kd_ext = C_W'($signed({1'b0, gain_d}));
  assign c_next = kp_ext * C_W'(s1_err) + ki_ext * C_W'(s1_sum) + kd_ext * C_W'(s1_d);

  always_ff @(posedge clk) begin
    if (s1_v && s2_rdy) begin
      s2_c   <= c_next;
      s2_err <= s1_err;
    end
  end

  // output stage: steering and drive clamp
  logic signed [ACC_W-1:0]   base_ext;
  logic signed [DRIVE_W-1:0] left_next, right_next;
  logic signed [DRIVE_W-1:0] out_left, out_right;
  logic signed [ERR_W-1:0]   out_err;

  assign base_ext = ACC_W'($signed({1'b0, base_speed}));

  always_comb begin
    if (s2_c > 0) begin
      left_next  = clamp_drive(base_ext + ACC_W'(s2_c));
      right_next = '0;
    end else if (s2_c < 0) begin
      left_next  = '0;
      right_next = clamp_drive(base_ext - ACC_W'(s2_c));
    end else begin
      left_next  = clamp_drive(base_ext);
      right_next = clamp_drive(base_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v && out_rdy) begin
      out_left  <= left_next;
      out_right <= right_next;
      out_err   <= s2_err;
    end
  end

  assign m_tdata = {5'b0, out_err, out_right, out_left};

  // checks
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_err >= ERR_RIGHT_TWO && out_err <= ERR_LEFT_TWO))
    else $error("position error out of range");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_left == 0 || out_right == 0 || out_left == out_right))
    else $error("both wheel pairs driven with different speeds");

  a_drive_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_left != 16'sh8000 && out_right != 16'sh8000))
    else $error("drive clamp missed negative full scale");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_v |-> s_tready)
    else $error("input stalled with empty input register");

  a_state_track: assert property (@(posedge clk) disable iff (rst)
    (in_v && s1_rdy) |=> (prev_error == s1_err && error_sum == s1_sum))
    else $error("pid state and stage one disagree");

endmodule

### bench/tb_line_follow_pid_drive.sv
// self-checking stream testbench for the five-sensor pid line follower drive
module tb_line_follow_pid_drive;
  timeunit 1ns;
  timeprecision 1ps;

  import lfpd_pkg::*;

  // far_left in the lowest bits, as on s_tdata
  typedef struct packed {
    logic [SAMPLE_W-1:0] far_right;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] far_left;
  } scan_t;

  // left_drive in the lowest bits, as on m_tdata
  typedef struct packed {
    logic signed [ERR_W-1:0]   pos_err;
    logic signed [DRIVE_W-1:0] right;
    logic signed [DRIVE_W-1:0] left;
  } drive_t;

  // see masks: [4] far left .. [0] far right; the first entry ignores both outer sensors
  localparam logic [4:0] LINE_PATTERNS [6] = '{5'b00100, 5'b00010, 5'b01000,
                                                5'b00001, 5'b10000, 5'b11100};
  localparam int SCAN_BITS = 5 * SAMPLE_W;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // predictor copy of the registers and the pid state
  int thr_reg = THRESHOLD_RST;
  int gain_p_reg = GAIN_P_RST;
  int gain_i_reg = GAIN_I_RST;
  int gain_d_reg = GAIN_D_RST;
  int base_reg = BASE_RST;
  int prev_err = 0;
  int err_sum = 0;

  scan_t pending_scans[$];
  drive_t expected_drives[$];
  scan_t offered;
  int in_count = 0;
  int mismatches = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic calm;

  assign calm = (in_count >= 100) && (in_count < 220);

  line_follow_pid_drive uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic longint clip_drive(input longint v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  // advances the pid state by one tick and returns the wheel commands
  function automatic drive_t steer_tick(input scan_t s);
    logic fl, lf, md, rt, fr;
    int err, sum, dlt;
    longint corr, lft, rgt;
    drive_t res;
    fl = s.far_left < thr_reg;
    lf = s.left < thr_reg;
    md = s.mid < thr_reg;
    rt = s.right < thr_reg;
    fr = s.far_right < thr_reg;
    err = prev_err;
    if (md && !lf && !rt) err = 0;
    else if (rt && !fl && !lf && !md && !fr) err = -1;
    else if (lf && !fl && !md && !rt && !fr) err = 1;
    else if (fr && !fl && !lf && !md && !rt) err = -2;
    else if (fl && !lf && !md && !rt && !fr) err = 2;
    else if (fl && lf && md && !rt && !fr) err = 0;
    sum = err_sum + err;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    err_sum = sum;
    dlt = err - prev_err;
    prev_err = err;
    corr = longint'(gain_p_reg) * err + longint'(gain_i_reg) * sum
         + longint'(gain_d_reg) * dlt;
    if (corr > 0) begin
      lft = clip_drive(base_reg + corr);
      rgt = 0;
    end else if (corr < 0) begin
      lft = 0;
      rgt = clip_drive(base_reg - corr);
    end else begin
      lft = clip_drive(base_reg);
      rgt = lft;
    end
    res.left = lft[DRIVE_W-1:0];
    res.right = rgt[DRIVE_W-1:0];
    res.pos_err = err[ERR_W-1:0];
    return res;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic sees);
    if (sees && thr_reg > 0) return SAMPLE_W'($urandom_range(thr_reg - 1, 0));
    return SAMPLE_W'($urandom_range(1023, thr_reg));
  endfunction

  // sample at or just under the threshold, or anywhere
  function automatic logic [SAMPLE_W-1:0] pick_noise();
    int v;
    case ($urandom_range(2))
      0: v = thr_reg > 1023 ? 1023 : thr_reg;
      1: v = thr_reg > 0 ? thr_reg - 1 : 0;
      default: v = $urandom_range(1023);
    endcase
    return SAMPLE_W'(v);
  endfunction

  function automatic void queue_raw(input int fl, input int lf, input int md,
                                    input int rt, input int fr);
    scan_t s;
    s.far_left = SAMPLE_W'(fl);
    s.left = SAMPLE_W'(lf);
    s.mid = SAMPLE_W'(md);
    s.right = SAMPLE_W'(rt);
    s.far_right = SAMPLE_W'(fr);
    pending_scans.push_back(s);
  endfunction

  function automatic void queue_mask(input logic [4:0] see);
    queue_raw(pick_sample(see[4]), pick_sample(see[3]), pick_sample(see[2]),
              pick_sample(see[1]), pick_sample(see[0]));
  endfunction

  function automatic void queue_random_scan();
    int roll, idx;
    logic [4:0] see;
    roll = $urandom_range(99);
    if (roll < 70) begin
      idx = $urandom_range(5);
      see = LINE_PATTERNS[idx];
      if (idx == 0) begin
        see[4] = 1'($urandom_range(1));
        see[0] = 1'($urandom_range(1));
      end
      queue_mask(see);
    end else if (roll < 85) begin
      queue_mask(5'($urandom_range(31)));
    end else begin
      queue_raw(pick_noise(), pick_noise(), pick_noise(), pick_noise(), pick_noise());
    end
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_reg = value & ((1 << THR_W) - 1);
      REG_GAIN_P:    gain_p_reg = value & ((1 << GAIN_W) - 1);
      REG_GAIN_I:    gain_i_reg = value & ((1 << GAIN_W) - 1);
      REG_GAIN_D:    gain_d_reg = value & ((1 << GAIN_W) - 1);
      REG_BASE:      base_reg = value & ((1 << BASE_W) - 1);
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [APB_DATA_W-1:0] thr, input logic [APB_DATA_W-1:0] kp,
                           input logic [APB_DATA_W-1:0] ki, input logic [APB_DATA_W-1:0] kd,
                           input logic [APB_DATA_W-1:0] base);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_BASE, base);
  endtask

  task automatic wait_drained();
    while (pending_scans.size() != 0 || expected_drives.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %0d got %0d", what, want, got);
  endtask

  // sensor beat source
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_drives.push_back(steer_tick(offered));
        in_count <= in_count + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_scans.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          offered = pending_scans.pop_front();
          s_tdata <= {{(IN_TDATA_W - SCAN_BITS){1'b0}}, offered};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink ready, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    drive_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(drive_t)-1:0];
      if (expected_drives.size() == 0) begin
        flag_mismatch("unexpected beat, left_drive", 0, got.left);
      end else begin
        want = expected_drives.pop_front();
        if (got.left !== want.left) flag_mismatch("left_drive", want.left, got.left);
        if (got.right !== want.right) flag_mismatch("right_drive", want.right, got.right);
        if (got.pos_err !== want.pos_err)
          flag_mismatch("position_error", want.pos_err, got.pos_err);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: every table pattern, misses, threshold edges, full-scale samples
    queue_raw(1023, 1023, 1023, 1023, 1023);
    queue_raw(0, 0, 0, 0, 0);
    queue_mask(5'b00100);
    queue_mask(5'b10101);
    queue_mask(5'b00010);
    queue_mask(5'b01000);
    queue_mask(5'b00001);
    queue_mask(5'b10000);
    queue_mask(5'b11100);
    queue_raw(400, 400, 400, 400, 400);
    queue_raw(400, 400, 399, 400, 400);
    queue_mask(5'b01010);
    queue_mask(5'b00010);
    queue_mask(5'b01000);
    queue_mask(5'b00001);
    queue_mask(5'b10000);
    wait_drained();

    // threshold and gain extremes
    write_all(0, 4095, 4095, 4095, 8191);
    queue_raw(0, 0, 0, 0, 0);
    wait_drained();
    write_reg(REG_THRESHOLD, 1023);
    queue_raw(1022, 1022, 1022, 1022, 1022);
    queue_raw(1023, 1023, 1022, 1023, 1023);
    queue_raw(1022, 1023, 1023, 1023, 1023);
    queue_raw(1023, 1023, 1023, 1023, 1022);
    wait_drained();
    write_all(32'hFFFF_FC00 | 400, 0, 0, 0, 0);
    queue_mask(5'b10000);
    queue_mask(5'b00001);
    wait_drained();
    // upper pwdata bits must be dropped
    write_all(32'hFFFF_FC00 | 400, 32'hFFFF_F000 | 438, 32'hFFFF_F000 | 1,
              32'hFFFF_F000 | 384, 32'hFFFF_E000 | 1664);

    // ramp the integral up, then down through zero
    repeat (20) queue_mask(5'b10000);
    repeat (40) queue_mask(5'b00001);
    queue_mask(5'b00100);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_all(1023, 4095, 4095, 4095, 8191);
        1: write_all(1, 0, 0, 0, 0);
        2: write_all(400, 438, 0, 384, 1664);
        default: write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      endcase
      repeat (70) queue_random_scan();
      if (phase == 2) hold_req <= 1'b1;
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_drives.size() == 0) begin
      $display("tb_line_follow_pid_drive: PASS");
    end else begin
      $display("tb_line_follow_pid_drive: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_line_follow_pid_drive: FAIL");
    $finish;
  end

endmodule

### filelist.f
src/lfpd_pkg.sv
src/line_follow_pid_drive.sv
bench/tb_line_follow_pid_drive.sv
